// ----- rtl/phm_pkg.sv -----
// Package for the pattern hyphenation marker: item, result, command and
// configuration types, the pattern table and the pattern match function.
// No dependencies.
`timescale 1ns / 1ps

package phm_pkg;

  localparam int MaxWord   = 32;
  localparam int CntW      = $clog2(MaxWord + 1);
  localparam int IdxW      = $clog2(MaxWord);
  localparam int NumPats   = 62;
  localparam int HistLen   = 5;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  // UTF-8 lead byte classes
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [6:0] LowerBit  = 7'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       hyphen_after;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic       enable;
    logic [6:0] min_word_length;
    logic [5:0] left_margin;
    logic [5:0] right_margin;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_MIN_LEN = 2'd1,
    CFG_LEFT    = 2'd2,
    CFG_RIGHT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_LETTER,
    CMD_BYTE,
    CMD_FLUSH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic       marked;
    logic       last;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_FLUSH
  } back_state_t;

  // Patterns, right-aligned: byte 0 is the last letter of the pattern
  localparam logic [8*HistLen-1:0] PatTxt [NumPats] = '{
    "tion", "sion", "ing", "ment", "ness",
    "able", "ible", "ful", "less", "ous",
    "ive", "ure", "ize", "ise", "ly",
    "er", "ed", "es",
    "pre", "pro", "con", "com", "dis",
    "mis", "sub", "super", "inter", "under",
    "over", "anti", "auto", "semi",
    "ble", "cle", "dle", "fle", "gle",
    "kle", "ple", "tle", "zle",
    "bb", "cc", "dd", "ff", "gg", "ll",
    "mm", "nn", "pp", "rr", "ss", "tt",
    "zz",
    "ation", "ition", "ution", "ction",
    "acter", "ument", "ement", "iment"
  };

  localparam logic [2:0] PatLen [NumPats] = '{
    3'd4, 3'd4, 3'd3, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd3, 3'd4, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd2,
    3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd5, 3'd5, 3'd5,
    3'd4, 3'd4, 3'd4, 3'd4,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2,
    3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [2:0] PatMark [NumPats] = '{
    3'd2, 3'd2, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd5, 3'd5, 3'd5,
    3'd4, 3'd4, 3'd4, 3'd4,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1,
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2
  };

  // Match all patterns that end at the newest letter. Bit d of the result
  // asks for a break mark d places back from the current letter count.
  function automatic logic [HistLen-1:0] pat_offsets(
    input logic [8*HistLen-1:0] hist,
    input logic [CntW-1:0]      n
  );
    logic [HistLen-1:0] offs;
    logic               hit;
    logic [2:0]         back;
    offs = '0;
    for (int p = 0; p < NumPats; p++) begin
      hit = ({{(CntW-3){1'b0}}, PatLen[p]} <= n);
      for (int m = 0; m < HistLen; m++) begin
        if ((3'(m) < PatLen[p]) && (hist[m*8 +: 8] != PatTxt[p][m*8 +: 8])) begin
          hit = 1'b0;
        end
      end
      back = PatLen[p] - PatMark[p];
      if (hit) begin
        offs[back] = 1'b1;
      end
    end
    return offs;
  endfunction

endpackage

// ----- rtl/phm_cmd_fifo.sv -----
// Command queue between the front classifier and the back emitter.
// Depends on phm_pkg (cmd_t, FifoDepth).
`timescale 1ns / 1ps

module phm_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  phm_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output phm_pkg::cmd_t rd_cmd,
  output logic          q_empty
);

  phm_pkg::cmd_t                   slots [phm_pkg::FifoDepth];
  logic [phm_pkg::FifoPtrW-1:0]    wr_ptr;
  logic [phm_pkg::FifoPtrW-1:0]    rd_ptr;
  logic [phm_pkg::FifoPtrW:0]      fill;

  assign q_full  = (fill == (phm_pkg::FifoPtrW+1)'(phm_pkg::FifoDepth));
  assign q_empty = (fill == '0);
  assign rd_cmd  = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) fill <= fill + 1'b1;
      else if (rd_en && !wr_en) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- rtl/phm_front.sv -----
// Front part: accepts text bytes, tracks word length, overlong and UTF-8
// state, and turns each item into up to three commands for the back part.
// Depends on phm_pkg.
`timescale 1ns / 1ps

module phm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  phm_pkg::in_item_t item,
  input  logic              enable,
  input  logic              cmd_full,
  output logic              cmd_push,
  output phm_pkg::cmd_t     cmd
);

  phm_pkg::cmd_t             slot [3];
  logic [2:0]                slot_vld;
  logic [phm_pkg::CntW-1:0]  cnt;
  logic                      ovl;
  logic [1:0]                pend;

  phm_pkg::cmd_t             new_slot [3];
  logic [2:0]                new_vld;
  logic [phm_pkg::CntW-1:0]  cnt_next;
  logic                      ovl_next;
  logic [1:0]                pend_next;
  logic                      accept;
  logic                      letter;
  logic [7:0]                b;
  logic [1:0]                sel;

  assign full   = |slot_vld;
  assign accept = push && !full;
  assign b      = item.text_byte;
  assign letter = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));

  // Classify the item into flush, byte/letter and end-of-text flush slots
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      new_slot[s] = '{op: phm_pkg::CMD_BYTE, data: b, marked: 1'b0, last: 1'b0};
    end
    new_vld   = '0;
    cnt_next  = cnt;
    ovl_next  = ovl;
    pend_next = pend;
    if (!enable) begin
      if (cnt != '0) begin
        new_vld[0]   = 1'b1;
        new_slot[0].op = phm_pkg::CMD_FLUSH;
      end
      new_vld[1] = 1'b1;
      cnt_next   = '0;
      ovl_next   = 1'b0;
      pend_next  = '0;
    end else if (pend != '0) begin
      new_vld[1] = 1'b1;
      pend_next  = pend - 1'b1;
    end else if (letter) begin
      if (ovl) begin
        new_vld[1] = 1'b1;
      end else if (cnt < phm_pkg::CntW'(phm_pkg::MaxWord)) begin
        new_vld[1]     = 1'b1;
        new_slot[1].op = phm_pkg::CMD_LETTER;
        cnt_next       = cnt + 1'b1;
      end else begin
        new_vld[0]     = 1'b1;
        new_slot[0].op = phm_pkg::CMD_FLUSH;
        new_vld[1]     = 1'b1;
        cnt_next       = '0;
        ovl_next       = 1'b1;
      end
    end else begin
      if (cnt != '0) begin
        new_vld[0]         = 1'b1;
        new_slot[0].op     = phm_pkg::CMD_FLUSH;
        new_slot[0].marked = 1'b1;
      end
      new_vld[1] = 1'b1;
      cnt_next   = '0;
      ovl_next   = 1'b0;
      if ((b & phm_pkg::Lead2Mask) == phm_pkg::Lead2Code) pend_next = 2'd1;
      else if ((b & phm_pkg::Lead3Mask) == phm_pkg::Lead3Code) pend_next = 2'd2;
      else if ((b & phm_pkg::Lead4Mask) == phm_pkg::Lead4Code) pend_next = 2'd3;
    end
    if (item.end_of_text) begin
      if (cnt_next != '0) begin
        new_vld[2]         = 1'b1;
        new_slot[2].op     = phm_pkg::CMD_FLUSH;
        new_slot[2].marked = enable;
      end
      cnt_next  = '0;
      ovl_next  = 1'b0;
      pend_next = '0;
    end
    // Tag the last command that yields a result
    if (new_vld[2]) new_slot[2].last = 1'b1;
    else if (new_vld[1] && (new_slot[1].op == phm_pkg::CMD_BYTE)) new_slot[1].last = 1'b1;
    else if (new_vld[0]) new_slot[0].last = 1'b1;
  end

  // Issue the oldest pending slot
  always_comb begin
    if (slot_vld[0]) sel = 2'd0;
    else if (slot_vld[1]) sel = 2'd1;
    else sel = 2'd2;
  end

  assign cmd_push = full && !cmd_full;
  assign cmd      = slot[sel];

  // Hold slot payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int s = 0; s < 3; s++) begin
        slot[s] <= new_slot[s];
      end
    end
  end

  // Track word state and slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      cnt      <= '0;
      ovl      <= 1'b0;
      pend     <= '0;
    end else if (accept) begin
      slot_vld <= new_vld;
      cnt      <= cnt_next;
      ovl      <= ovl_next;
      pend     <= pend_next;
    end else if (cmd_push) begin
      slot_vld[sel] <= 1'b0;
    end
  end

endmodule

// ----- rtl/phm_back.sv -----
// Back part: stores word letters, matches patterns per letter, and emits
// bytes and flushed words with hyphen flags through a one-entry output stage.
// Depends on phm_pkg.
`timescale 1ns / 1ps

module phm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  phm_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  phm_pkg::cfg_t      cfg,
  input  logic               res_pop,
  output logic               res_valid,
  output phm_pkg::out_item_t res
);

  phm_pkg::back_state_t               state;
  phm_pkg::back_state_t               state_next;
  logic [6:0]                         letters [phm_pkg::MaxWord];
  logic [6:0]                         rdata;
  logic [phm_pkg::CntW-1:0]           cnt;
  logic [phm_pkg::MaxWord:0]          marks;
  logic [8*phm_pkg::HistLen-1:0]      hist;
  logic [phm_pkg::IdxW-1:0]           idx;
  logic                               fl_marked;
  logic                               fl_last;

  logic                               out_free;
  logic                               load;
  phm_pkg::out_item_t                 load_item;
  logic                               at_end;
  logic                               hy;
  logic                               marked_eff;
  logic [phm_pkg::IdxW-1:0]           rd_addr;
  logic [8*phm_pkg::HistLen-1:0]      hist_new;
  logic [phm_pkg::CntW-1:0]           n_new;
  logic [phm_pkg::HistLen-1:0]        offs;
  logic [phm_pkg::MaxWord:0]          marks_add;
  logic                               take_letter;
  logic                               take_flush;

  assign out_free = !res_valid || res_pop;
  assign at_end   = ({1'b0, idx} == (cnt - 1'b1));

  // Hyphen decision for the letter at idx
  assign marked_eff = fl_marked && ({1'b0, cnt} >= cfg.min_word_length);
  assign hy = marked_eff && marks[{1'b0, idx} + 1'b1]
           && (({1'b0, idx} + 1'b1) >= cfg.left_margin)
           && (({2'b0, idx} + {1'b0, cfg.right_margin}) < {1'b0, cnt});

  // Pattern hits for the incoming letter
  assign hist_new = {hist[8*(phm_pkg::HistLen-1)-1:0], 1'b0, cmd.data[6:0] | phm_pkg::LowerBit};
  assign n_new    = cnt + 1'b1;
  assign offs     = phm_pkg::pat_offsets(hist_new, n_new);

  always_comb begin
    marks_add = '0;
    for (int j = 0; j <= phm_pkg::MaxWord; j++) begin
      for (int d = 0; d < phm_pkg::HistLen; d++) begin
        if (offs[d] && ({1'b0, n_new} == 7'(j + d))) begin
          marks_add[j] = 1'b1;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      phm_pkg::BK_IDLE: begin
        if (!cmd_empty && (cmd.op == phm_pkg::CMD_FLUSH)) state_next = phm_pkg::BK_FLUSH;
      end
      phm_pkg::BK_FLUSH: begin
        if (out_free && at_end) state_next = phm_pkg::BK_IDLE;
      end
      default: state_next = phm_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_pop     = 1'b0;
    load        = 1'b0;
    load_item   = '0;
    take_letter = 1'b0;
    take_flush  = 1'b0;
    unique case (state)
      phm_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.op)
            phm_pkg::CMD_LETTER: begin
              cmd_pop     = 1'b1;
              take_letter = 1'b1;
            end
            phm_pkg::CMD_BYTE: begin
              if (out_free) begin
                cmd_pop   = 1'b1;
                load      = 1'b1;
                load_item = '{out_byte: cmd.data, hyphen_after: 1'b0, run_last: cmd.last};
              end
            end
            phm_pkg::CMD_FLUSH: begin
              cmd_pop    = 1'b1;
              take_flush = 1'b1;
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      phm_pkg::BK_FLUSH: begin
        if (out_free) begin
          load      = 1'b1;
          load_item = '{out_byte: {1'b0, rdata}, hyphen_after: hy,
                        run_last: at_end && fl_last};
        end
      end
      default: ;
    endcase
  end

  assign rd_addr = ((state == phm_pkg::BK_FLUSH) && out_free && !at_end) ? idx + 1'b1 : idx;

  // Letter store: write on letter, registered read for the flush walk
  always_ff @(posedge clk) begin
    if (take_letter) begin
      letters[cnt[phm_pkg::IdxW-1:0]] <= cmd.data[6:0];
    end
    rdata <= letters[rd_addr];
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    if (take_letter) hist <= hist_new;
    if (take_flush) begin
      fl_marked <= cmd.marked;
      fl_last   <= cmd.last;
    end
    if (load) res <= load_item;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= phm_pkg::BK_IDLE;
      cnt       <= '0;
      marks     <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
      if (take_letter) begin
        cnt   <= n_new;
        marks <= marks | marks_add;
      end
      if ((state == phm_pkg::BK_FLUSH) && out_free) begin
        if (at_end) begin
          idx   <= '0;
          cnt   <= '0;
          marks <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/pattern_hyphenation_marker.sv -----
// A word flush emits one letter per cycle from the letter store while the
// output stage is free. The front takes a new item only once it has issued
// every command of the previous item, one command per cycle into the command
// queue while it is not full; the front stalls while the back walks a
// flushed word and the queue fills.
// Reset: synchronous; clears queues, word state and output stage, and loads
// the register defaults. The letter store is not cleared.
`timescale 1ns / 1ps

module pattern_hyphenation_marker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  phm_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output phm_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  phm_pkg::cfg_t cfg;
  phm_pkg::cmd_t front_cmd;
  phm_pkg::cmd_t back_cmd;
  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_full;
  logic          cmd_empty;
  logic          res_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{enable: 1'b1, min_word_length: 7'd5, left_margin: 6'd2, right_margin: 6'd3};
    end else if (cfg_valid && cfg_ready) begin
      unique case (phm_pkg::cfg_idx_t'(cfg_index))
        phm_pkg::CFG_ENABLE:  cfg.enable          <= cfg_data[0];
        phm_pkg::CFG_MIN_LEN: cfg.min_word_length <= cfg_data;
        phm_pkg::CFG_LEFT:    cfg.left_margin     <= cfg_data[5:0];
        phm_pkg::CFG_RIGHT:   cfg.right_margin    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  phm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .enable   (cfg.enable),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  phm_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_cmd  (front_cmd),
    .q_full  (cmd_full),
    .rd_en   (cmd_pop),
    .rd_cmd  (back_cmd),
    .q_empty (cmd_empty)
  );

  phm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res       (result)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(cmd_push && cmd_full))
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(cmd_pop && cmd_empty))
    else $error("command popped from an empty queue");

  a_item_makes_work: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("accepted item left no pending command");

  a_no_hyphen_disabled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !cfg.enable) |-> !result.hyphen_after)
    else $error("hyphen flag while marking is disabled");
`endif

endmodule

// ----- tb/sv/phm_checker.sv -----
// Checker for the pattern hyphenation marker: watches the item, result and
// register channels, predicts each result and compares it with the block.
// Depends on phm_pkg for the item, result and register index types.
`timescale 1ns / 1ps

module phm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  phm_pkg::in_item_t  item,
  input  logic               empty,
  input  logic               pop,
  input  phm_pkg::out_item_t result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output int                 errors,
  output int                 outstanding,
  output int                 checked
);

  localparam int WordMax = phm_pkg::MaxWord;

  // break patterns with the letter count before the break point
  string pat_text [62] = '{
    "tion", "sion", "ing", "ment", "ness", "able", "ible", "ful", "less", "ous",
    "ive", "ure", "ize", "ise", "ly", "er", "ed", "es",
    "pre", "pro", "con", "com", "dis", "mis", "sub", "super", "inter", "under",
    "over", "anti", "auto", "semi",
    "ble", "cle", "dle", "fle", "gle", "kle", "ple", "tle", "zle",
    "bb", "cc", "dd", "ff", "gg", "ll", "mm", "nn", "pp", "rr", "ss", "tt", "zz",
    "ation", "ition", "ution", "ction", "acter", "ument", "ement", "iment"
  };
  int pat_break [62] = '{
    2, 2, 1, 1, 1, 1, 1, 1, 1, 1,
    1, 1, 1, 1, 1, 1, 1, 1,
    3, 3, 3, 3, 3, 3, 3, 5, 5, 5,
    4, 4, 4, 4,
    1, 1, 1, 1, 1, 1, 1, 1, 1,
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
    2, 2, 2, 2, 2, 2, 2, 2
  };

  phm_pkg::out_item_t expected_results [$];
  logic [6:0] word_buf [WordMax];
  bit         break_at [WordMax+1];
  int         word_len;
  bit         overlong;
  int         utf8_left;
  bit         mark_on;
  int         min_len;
  int         left_keep;
  int         right_keep;

  function automatic bit pattern_fits(int pos, int p, int n);
    int  plen;
    byte c;
    plen = pat_text[p].len();
    if (pos + plen > n) return 0;
    for (int j = 0; j < plen; j++) begin
      c = byte'({1'b0, word_buf[pos+j] | 7'h20});
      if (c != pat_text[p][j]) return 0;
    end
    return 1;
  endfunction

  function automatic void emit_byte(logic [7:0] b, bit hy);
    phm_pkg::out_item_t r;
    r.out_byte     = b;
    r.hyphen_after = hy;
    r.run_last     = 1'b0;
    expected_results.push_back(r);
  endfunction

  // release the buffered word, marked only when asked and long enough
  function automatic void release_word(bit marked);
    bit hy;
    for (int i = 0; i <= WordMax; i++) break_at[i] = 0;
    if (marked && word_len >= min_len) begin
      for (int i = 0; i < word_len; i++)
        for (int p = 0; p < 62; p++)
          if (pattern_fits(i, p, word_len)) break_at[i + pat_break[p]] = 1;
    end
    for (int i = 0; i < word_len; i++) begin
      hy = break_at[i+1] && (i + 1 >= left_keep) && (i + right_keep < word_len);
      emit_byte({1'b0, word_buf[i]}, hy);
    end
    word_len = 0;
  endfunction

  function automatic void predict_item(phm_pkg::in_item_t it);
    int         base;
    logic [7:0] b;
    bit         is_letter;
    base = expected_results.size();
    b = it.text_byte;
    is_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    if (!mark_on) begin
      release_word(0);
      emit_byte(b, 0);
      overlong = 0;
      utf8_left = 0;
    end else if (utf8_left > 0) begin
      emit_byte(b, 0);
      utf8_left--;
    end else if (is_letter) begin
      if (overlong) begin
        emit_byte(b, 0);
      end else if (word_len < WordMax) begin
        word_buf[word_len] = b[6:0];
        word_len++;
      end else begin
        release_word(0);
        emit_byte(b, 0);
        overlong = 1;
      end
    end else begin
      release_word(1);
      emit_byte(b, 0);
      overlong = 0;
      if ((b & phm_pkg::Lead2Mask) == phm_pkg::Lead2Code) utf8_left = 1;
      else if ((b & phm_pkg::Lead3Mask) == phm_pkg::Lead3Code) utf8_left = 2;
      else if ((b & phm_pkg::Lead4Mask) == phm_pkg::Lead4Code) utf8_left = 3;
    end
    if (it.end_of_text) begin
      release_word(mark_on);
      overlong = 0;
      utf8_left = 0;
    end
    if (expected_results.size() > base)
      expected_results[expected_results.size()-1].run_last = 1'b1;
  endfunction

  always @(posedge clk) begin
    phm_pkg::out_item_t want;
    if (rst) begin
      expected_results.delete();
      word_len   = 0;
      overlong   = 0;
      utf8_left  = 0;
      mark_on    = 1;
      min_len    = 5;
      left_keep  = 2;
      right_keep = 3;
      errors      <= 0;
      checked     <= 0;
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (phm_pkg::cfg_idx_t'(cfg_index))
          phm_pkg::CFG_ENABLE:  mark_on    = cfg_data[0];
          phm_pkg::CFG_MIN_LEN: min_len    = cfg_data;
          phm_pkg::CFG_LEFT:    left_keep  = cfg_data[5:0];
          phm_pkg::CFG_RIGHT:   right_keep = cfg_data[5:0];
          default: ;
        endcase
      end
      if (push && !full) predict_item(item);
      // compare the popped result with the oldest expectation
      if (pop && !empty) begin
        checked <= checked + 1;
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result byte=%h hy=%b last=%b", $time,
                   result.out_byte, result.hyphen_after, result.run_last);
        end else begin
          want = expected_results.pop_front();
          if (want.out_byte != result.out_byte ||
              want.hyphen_after != result.hyphen_after ||
              want.run_last != result.run_last) begin
            errors <= errors + 1;
            $display("%0t: result mismatch expected byte=%h hy=%b last=%b, got byte=%h hy=%b last=%b",
                     $time, want.out_byte, want.hyphen_after, want.run_last,
                     result.out_byte, result.hyphen_after, result.run_last);
          end
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the pattern hyphenation marker testbench: clock, reset, stimulus
// and verdict. Depends on phm_pkg, pattern_hyphenation_marker and phm_checker.
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 800000;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  phm_pkg::in_item_t  item;
  logic      empty;
  logic      pop;
  phm_pkg::out_item_t result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int        errors;
  int        outstanding;
  int        checked;

  int  cycles = 0;
  int  items_sent;
  int  phases_run;
  bit  steady;
  bit  hold_req;
  bit  hold_done;
  bit  push_high;

  string syllables [16] = '{
    "con", "tion", "ing", "er", "ll", "ment", "pre", "a",
    "o", "super", "ble", "st", "ation", "ness", "e", "ump"
  };

  pattern_hyphenation_marker dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  phm_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding), .checked(checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // offer one item, idling first for a random gap
  task automatic send_byte(logic [7:0] b, bit eot);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0 && push_high) begin
      push <= 1'b0;
      push_high = 0;
    end
    repeat (gap) @(posedge clk);
    push <= 1'b1;
    push_high = 1;
    item.text_byte   <= b;
    item.end_of_text <= eot;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    if (push_high) begin
      push <= 1'b0;
      push_high = 0;
    end
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(phm_pkg::cfg_idx_t idx, logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // a word of syllables in random case, or rarely an overlong run of letters
  task automatic send_word();
    string w;
    int    target;
    byte   c;
    w = "";
    if ($urandom_range(0, 14) == 0) begin
      target = $urandom_range(33, 40);
      repeat (target) w = {w, string'(byte'("a" + $urandom_range(0, 25)))};
    end else begin
      target = $urandom_range(1, 14);
      while (w.len() < target) w = {w, syllables[$urandom_range(0, 15)]};
    end
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ($urandom_range(0, 3) == 0) c = c - 8'd32;
      send_byte(c, (i == w.len() - 1) && ($urandom_range(0, 19) == 0));
    end
  endtask

  // end the word with a space, punctuation, a multibyte sequence or noise
  task automatic send_break();
    int kind;
    int tail;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      send_byte(" ", $urandom_range(0, 15) == 0);
    end else if (kind < 6) begin
      send_byte($urandom_range(0, 2) == 0 ? "-" : ".", 0);
    end else if (kind < 8) begin
      tail = $urandom_range(1, 3);
      case (tail)
        1: send_byte(8'hC0 | 8'($urandom_range(0, 31)), 0);
        2: send_byte(8'hE0 | 8'($urandom_range(0, 15)), 0);
        default: send_byte(8'hF0 | 8'($urandom_range(0, 7)), 0);
      endcase
      for (int i = 0; i < tail; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  // consume results with random stalls and one long hold-off on request
  initial begin
    int gap;
    pop = 1'b0;
    hold_done = 0;
    @(negedge rst);
    forever begin
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    logic [6:0] settings [8][4] = '{
      '{7'd1, 7'd5,   7'd2,  7'd3},
      '{7'd1, 7'd0,   7'd0,  7'd0},
      '{7'd1, 7'd1,   7'd1,  7'd1},
      '{7'd0, 7'd5,   7'd2,  7'd3},
      '{7'd1, 7'd127, 7'd63, 7'd63},
      '{7'd1, 7'd3,   7'd1,  7'd2},
      '{7'd1, 7'd64,  7'd1,  7'd1},
      '{7'd1, 7'd2,   7'd4,  7'd1}
    };
    int start;
    rst       = 1'b1;
    push      = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    items_sent = 0;
    phases_run = 0;
    steady    = 0;
    hold_req  = 0;
    push_high = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed text at the reset settings: suffix breaks, multibyte
    // sequences, a lone high byte, end inside a sequence, a held word
    send_text("Ration ");
    send_byte(8'hC3, 0);
    send_byte("A", 0);
    send_byte(8'hE2, 0);
    send_byte(8'h80, 0);
    send_byte(8'h94, 0);
    send_byte(8'hFF, 0);
    send_byte(8'hF0, 1);
    send_text("ZZ");
    send_byte(8'h00, 1);
    send_text("bottle");
    send_byte("s", 1);
    drain();

    // random text under each register setting
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(phm_pkg::CFG_ENABLE,  settings[ph][0]);
      write_reg(phm_pkg::CFG_MIN_LEN, settings[ph][1]);
      write_reg(phm_pkg::CFG_LEFT,    settings[ph][2]);
      write_reg(phm_pkg::CFG_RIGHT,   settings[ph][3]);
      steady   = (ph == 5);
      hold_req = (ph == 2);
      start = items_sent;
      while (items_sent - start < 36) begin
        send_word();
        send_break();
      end
      drain();
      phases_run++;
    end

    $display("Sent %0d items over %0d register settings; %0d results checked.",
             items_sent, phases_run, checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/phm_pkg.sv
rtl/phm_cmd_fifo.sv
rtl/phm_front.sv
rtl/phm_back.sv
rtl/pattern_hyphenation_marker.sv
tb/sv/phm_checker.sv
tb/sv/tb.sv
